[hw/rtl/ppm_pkg.sv]
// shared types and constants for the permuted pattern matcher
// used by ppm_class, ppm_cell and permuted_pattern_matcher; no dependencies
`default_nettype none

package ppm_pkg;

    localparam int LETTER_W        = 5;
    localparam int CODES           = 32;
    localparam int LETTERS         = 26;
    localparam int IDX_W           = 6;
    localparam int LEN_W           = 7;
    localparam int REQ_W           = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 60;
    localparam int PERM_HI_W       = 10;
    localparam int PERM_W          = 2 * CFG_DATA_W + PERM_HI_W;
    localparam int PATTERN_MAX_DEF = 64;
    localparam int ALPHABET_DEF    = 26;

    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PERM_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERM_MID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERM_HI  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 2'd3;

    localparam logic [LEN_W-1:0] LENGTH_RESET = 7'd1;

    typedef struct packed {
        logic                text;
        logic                clear;
        logic [LETTER_W-1:0] letter;
    } t_cell_ctl;

endpackage

`default_nettype wire

[hw/rtl/ppm_class.sv]
// letter class decode: which stored letter codes accept the incoming text letter
// depends on ppm_pkg
`default_nettype none

module ppm_class #(
    parameter int ALPHABET = ppm_pkg::ALPHABET_DEF
) (
    input  wire logic [ppm_pkg::PERM_W-1:0]   i_perm,
    input  wire logic [ppm_pkg::LETTER_W-1:0] i_letter,
    output logic      [ppm_pkg::CODES-1:0]    o_class
);

    for (genvar s = 0; s < ppm_pkg::CODES; s++) begin : g_code
        localparam logic [ppm_pkg::LETTER_W-1:0] CODE = ppm_pkg::LETTER_W'(s);
        if (s < ppm_pkg::LETTERS && s < ALPHABET) begin : g_img
            assign o_class[s] = (i_letter == CODE) ||
                                (i_perm[ppm_pkg::LETTER_W*s +: ppm_pkg::LETTER_W] == i_letter);
        end else begin : g_plain
            assign o_class[s] = (i_letter == CODE);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ppm_cell.sv]
// one pattern position: stored letter and its shift-and match bit
// depends on ppm_pkg
`default_nettype none

module ppm_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ppm_pkg::t_cell_ctl           i_ctl,
    input  wire logic                         i_load,
    input  wire logic                         i_en,
    input  wire logic                         i_prev,
    input  wire logic [ppm_pkg::CODES-1:0]    i_class,
    output logic                              o_match,
    output logic                              o_next
);

    logic [ppm_pkg::LETTER_W-1:0] r_letter;
    logic                         r_match;
    logic                         n_match;

    always_comb begin
        n_match = r_match;
        if (i_ctl.clear) begin
            n_match = 1'b0;
        end else if (i_ctl.text) begin
            n_match = i_prev && i_en && i_class[r_letter];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_letter <= i_ctl.letter;
        end
    end

    assign o_match = r_match;
    assign o_next  = n_match;

endmodule

`default_nettype wire

[hw/rtl/permuted_pattern_matcher.sv]
// permuted pattern matcher top level: config registers, cell chain, output word register
// depends on ppm_pkg, ppm_class and ppm_cell
// a text word's result is offered in the cycle after it is accepted, once length letters are seen
// throughput: one input word per cycle while no output word waits unaccepted downstream
// reset zeroes perm, match bits, count, out valid; length to 1; pattern letters are not reset
`default_nettype none

module permuted_pattern_matcher #(
    parameter int PATTERN_MAX = ppm_pkg::PATTERN_MAX_DEF,
    parameter int ALPHABET    = ppm_pkg::ALPHABET_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [ppm_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic [ppm_pkg::IDX_W-1:0]        i_pattern_index,
    input  wire logic [ppm_pkg::LETTER_W-1:0]     i_letter,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_window_match,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ppm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ppm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int CW = (LW > ppm_pkg::LEN_W) ? LW : ppm_pkg::LEN_W;
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [ppm_pkg::CFG_DATA_W-1:0] r_perm_lo;
    logic [ppm_pkg::CFG_DATA_W-1:0] r_perm_mid;
    logic [ppm_pkg::PERM_HI_W-1:0]  r_perm_hi;
    logic [ppm_pkg::LEN_W-1:0]      r_len;
    logic [LW-1:0]                  r_seen;
    logic [LW-1:0]                  n_seen;
    logic                           r_out_valid;
    logic                           n_out_valid;
    logic                           r_out_bit;
    logic                           n_out_bit;

    logic                           w_in_acc;
    logic                           w_load;
    ppm_pkg::t_cell_ctl             w_ctl;
    logic [CW-1:0]                  w_len_raw;
    logic [CW-1:0]                  w_len;
    logic [CW-1:0]                  w_len_m1;
    logic [IW-1:0]                  w_last;
    logic [ppm_pkg::CODES-1:0]      w_class;
    logic [PATTERN_MAX-1:0]         w_match;
    logic [PATTERN_MAX-1:0]         w_next;

    assign o_in_ready     = !r_out_valid || i_out_ready;
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_window_match = r_out_bit;

    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_load       = w_in_acc && (i_req_type == ppm_pkg::REQ_LOAD);
    assign w_ctl.text   = w_in_acc && (i_req_type == ppm_pkg::REQ_TEXT);
    assign w_ctl.clear  = w_in_acc && (i_req_type == ppm_pkg::REQ_RESTART);
    assign w_ctl.letter = i_letter;

    // effective pattern length, clamped to one .. PATTERN_MAX
    assign w_len_raw = (r_len == '0) ? CW'(1) : CW'(r_len);
    assign w_len     = (w_len_raw > CW'(PATTERN_MAX)) ? CW'(PATTERN_MAX) : w_len_raw;
    assign w_len_m1  = w_len - CW'(1);
    assign w_last    = w_len_m1[IW-1:0];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_lo  <= '0;
            r_perm_mid <= '0;
            r_perm_hi  <= '0;
            r_len      <= ppm_pkg::LENGTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ppm_pkg::CFG_PERM_LO:  r_perm_lo  <= i_cfg_data;
                ppm_pkg::CFG_PERM_MID: r_perm_mid <= i_cfg_data;
                ppm_pkg::CFG_PERM_HI:  r_perm_hi  <= i_cfg_data[ppm_pkg::PERM_HI_W-1:0];
                ppm_pkg::CFG_LENGTH:   r_len      <= i_cfg_data[ppm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    ppm_class #(
        .ALPHABET (ALPHABET)
    ) u_class (
        .i_perm   ({r_perm_hi, r_perm_mid, r_perm_lo}),
        .i_letter (i_letter),
        .o_class  (w_class)
    );

    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        logic w_prev;
        logic w_sel;
        logic w_en;

        if (j == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_link
            assign w_prev = w_match[j-1];
        end

        if (j < (1 << ppm_pkg::IDX_W)) begin : g_addr
            assign w_sel = w_load && (i_pattern_index == ppm_pkg::IDX_W'(j));
        end else begin : g_noaddr
            assign w_sel = 1'b0;
        end

        assign w_en = (CW'(j) < w_len);

        ppm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_load  (w_sel),
            .i_en    (w_en),
            .i_prev  (w_prev),
            .i_class (w_class),
            .o_match (w_match[j]),
            .o_next  (w_next[j])
        );
    end

    // letter count since restart, saturating
    always_comb begin
        n_seen = r_seen;
        if (w_ctl.clear) begin
            n_seen = '0;
        end else if (w_ctl.text && (r_seen != LW'(PATTERN_MAX))) begin
            n_seen = r_seen + LW'(1);
        end
    end

    // output word register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_bit   = r_out_bit;
        if (w_in_acc) begin
            n_out_valid = w_ctl.text && (CW'(n_seen) >= w_len);
            if (w_ctl.text) begin
                n_out_bit = w_next[w_last];
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_bit <= n_out_bit;
    end

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clear |=> (r_seen == '0) && (w_match == '0))
        else $error("restart left match state behind");

    a_no_word_from_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_ctl.text) |=> !r_out_valid)
        else $error("output word from a non-text request");

    a_load_keeps_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (w_match == $past(w_match)))
        else $error("pattern load disturbed match bits");

    a_seen_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_seen) <= CW'(PATTERN_MAX))
        else $error("letter count beyond pattern maximum");

endmodule

`default_nettype wire
